FILE: src/pngunf_pkg.sv
// Shared types, constants and filter codes for the PNG scanline unfilter.
// Used by every module under src; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pngunf_pkg;

    localparam int MAX_ROW_PIXELS      = 512;
    localparam int MAX_BYTES_PER_PIXEL = 4;
    localparam int ROW_DEPTH           = MAX_ROW_PIXELS * MAX_BYTES_PER_PIXEL;

    localparam int POS_W    = $clog2(ROW_DEPTH);
    localparam int STRIDE_W = POS_W + 1;
    localparam int LANE_W   = $clog2(MAX_BYTES_PER_PIXEL);
    localparam int BPP_W    = 3;
    localparam int PIX_W    = 10;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [0:0] {
        CFG_BYTES_PER_PIXEL = 1'b0,
        CFG_ROW_PIXELS      = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        FILT_NONE    = 3'd0,
        FILT_SUB     = 3'd1,
        FILT_UP      = 3'd2,
        FILT_AVERAGE = 3'd3,
        FILT_PAETH   = 3'd4
    } t_filter;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_image;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       last_in_row;
        logic       bad_filter;
    } t_out_item;

    // Operands handed to the predictor
    typedef struct packed {
        t_filter    filter;
        logic [7:0] data_byte;
        logic [7:0] left;
        logic [7:0] up;
        logic [7:0] up_left;
    } t_pred_ops;

endpackage

`default_nettype wire

FILE: src/pngunf_line_buf.sv
// Row-above line buffer: one write port, one registered read port.
// Depends on pngunf_pkg for depth and address width.
`timescale 1ns / 1ps
`default_nettype none

module pngunf_line_buf
    import pngunf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [POS_W-1:0] i_wr_addr,
    input  wire logic [7:0]       i_wr_data,
    input  wire logic [POS_W-1:0] i_rd_addr,
    output logic      [7:0]       o_rd_data
);

    logic [7:0] r_mem [ROW_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Forward a same-edge write so the read returns the new byte
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: src/pngunf_predict.sv
// Filter predictor and byte reconstruction (None, Sub, Up, Average, Paeth).
// Purely combinational; depends on pngunf_pkg for the operand struct.
`timescale 1ns / 1ps
`default_nettype none

module pngunf_predict
    import pngunf_pkg::*;
(
    input  wire t_pred_ops  i_ops,
    output logic [7:0]      o_pixel_byte
);

    logic signed [9:0] s_a;
    logic signed [9:0] s_b;
    logic signed [9:0] s_c;
    logic signed [9:0] s_p;
    logic signed [9:0] s_pa;
    logic signed [9:0] s_pb;
    logic signed [9:0] s_pc;
    logic        [8:0] s_avg_sum;
    logic        [7:0] s_paeth;
    logic        [7:0] s_pred;

    always_comb begin
        s_a  = $signed({2'b00, i_ops.left});
        s_b  = $signed({2'b00, i_ops.up});
        s_c  = $signed({2'b00, i_ops.up_left});
        s_p  = s_a + s_b - s_c;
        s_pa = (s_p >= s_a) ? (s_p - s_a) : (s_a - s_p);
        s_pb = (s_p >= s_b) ? (s_p - s_b) : (s_b - s_p);
        s_pc = (s_p >= s_c) ? (s_p - s_c) : (s_c - s_p);

        // Ties go to left, then up
        if ((s_pa <= s_pb) && (s_pa <= s_pc)) begin
            s_paeth = i_ops.left;
        end else if (s_pb <= s_pc) begin
            s_paeth = i_ops.up;
        end else begin
            s_paeth = i_ops.up_left;
        end

        s_avg_sum = {1'b0, i_ops.left} + {1'b0, i_ops.up};

        case (i_ops.filter)
            FILT_SUB:     s_pred = i_ops.left;
            FILT_UP:      s_pred = i_ops.up;
            FILT_AVERAGE: s_pred = s_avg_sum[8:1];
            FILT_PAETH:   s_pred = s_paeth;
            default:      s_pred = 8'd0;
        endcase

        o_pixel_byte = i_ops.data_byte + s_pred;
    end

endmodule

`default_nettype wire

FILE: src/png_scanline_unfilter_unit.sv
// PNG scanline unfilter: input register, one pass of reconstruction, result register.
// An accepted request waits in the input register until the result register can take its
// result. Throughput: one byte per cycle while the result stream does not stall; the line
// buffer is read one position ahead, so its single read port keeps pace with the stream.
// Valid filter bytes and dropped bytes give no result; a bad filter byte gives a flagged one.
// Reset (i_rst_n low, synchronous): clears control state and the pixel delay lines;
// the line buffer is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module png_scanline_unfilter_unit
    import pngunf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_data,
    // Result stream
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data,
    // Configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire t_cfg_index            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [BPP_W-1:0]    r_bpp;
    logic [PIX_W-1:0]    r_row_pixels;

    // Input register
    logic                r_in_valid;
    t_in_item            r_in;

    // Reconstruction state
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    n_pos;
    logic                r_expect;
    logic                n_expect;
    t_filter             r_filter;
    t_filter             n_filter;
    logic                r_first_row;
    logic                n_first_row;
    logic                r_halted;
    logic                n_halted;
    logic [7:0]          r_left  [MAX_BYTES_PER_PIXEL];
    logic [7:0]          r_uleft [MAX_BYTES_PER_PIXEL];

    // Result register
    logic                r_out_valid;
    t_out_item           r_out;

    // Per-item work
    logic                s_go;
    logic                s_emit;
    logic                s_data_byte;
    logic                s_clear_lines;
    t_out_item           s_result;
    logic [BPP_W-1:0]    s_eff_bpp;
    logic [PIX_W-1:0]    s_eff_pix;
    logic [LANE_W-1:0]   s_lane;
    logic [STRIDE_W-1:0] s_stride;
    logic [STRIDE_W-1:0] s_pos_inc;
    logic [7:0]          s_up;
    logic [7:0]          s_above;
    logic [7:0]          s_pixel;
    t_pred_ops           s_ops;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp        <= BPP_W'(MAX_BYTES_PER_PIXEL);
            r_row_pixels <= PIX_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BYTES_PER_PIXEL: r_bpp        <= i_cfg_data[BPP_W-1:0];
                CFG_ROW_PIXELS:      r_row_pixels <= i_cfg_data[PIX_W-1:0];
                default:             r_bpp        <= r_bpp;
            endcase
        end
    end

    // Clamp the settings and form the row stride in bytes
    always_comb begin
        if (r_bpp == '0) begin
            s_eff_bpp = BPP_W'(1);
        end else if (r_bpp > BPP_W'(MAX_BYTES_PER_PIXEL)) begin
            s_eff_bpp = BPP_W'(MAX_BYTES_PER_PIXEL);
        end else begin
            s_eff_bpp = r_bpp;
        end
        if (r_row_pixels == '0) begin
            s_eff_pix = PIX_W'(1);
        end else if (r_row_pixels > PIX_W'(MAX_ROW_PIXELS)) begin
            s_eff_pix = PIX_W'(MAX_ROW_PIXELS);
        end else begin
            s_eff_pix = r_row_pixels;
        end
        s_lane   = LANE_W'(s_eff_bpp - BPP_W'(1));
        s_stride = STRIDE_W'(s_eff_bpp) * STRIDE_W'(s_eff_pix);
    end

    // Advance the input register whenever the work stage can take its request
    assign s_go       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !s_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (s_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Row above: read data always tracks the current byte position
    pngunf_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (s_go && s_data_byte),
        .i_wr_addr (r_pos),
        .i_wr_data (s_pixel),
        .i_rd_addr (n_pos),
        .o_rd_data (s_above)
    );

    // Up is zero on the first row of an image
    assign s_up = r_first_row ? 8'd0 : s_above;

    always_comb begin
        s_ops.filter    = r_filter;
        s_ops.data_byte = r_in.data_byte;
        s_ops.left      = r_left[s_lane];
        s_ops.up        = s_up;
        s_ops.up_left   = r_uleft[s_lane];
    end

    pngunf_predict u_predict (
        .i_ops        (s_ops),
        .o_pixel_byte (s_pixel)
    );

    assign s_pos_inc = STRIDE_W'(r_pos) + STRIDE_W'(1);

    // Sequencing of filter bytes, data bytes and the error halt
    always_comb begin
        n_pos         = r_pos;
        n_expect      = r_expect;
        n_filter      = r_filter;
        n_first_row   = r_first_row;
        n_halted      = r_halted;
        s_emit        = 1'b0;
        s_data_byte   = 1'b0;
        s_clear_lines = 1'b0;
        s_result      = '0;

        if (s_go) begin
            // A start marker abandons the current row and any halt
            if (r_in.first_of_image) begin
                n_halted    = 1'b0;
                n_first_row = 1'b1;
                n_expect    = 1'b1;
                n_pos       = '0;
            end
            if (!n_halted) begin
                if (n_expect) begin
                    if (r_in.data_byte > 8'(FILT_PAETH)) begin
                        n_halted            = 1'b1;
                        s_emit              = 1'b1;
                        s_result.bad_filter = 1'b1;
                    end else begin
                        n_filter      = t_filter'(r_in.data_byte[2:0]);
                        n_expect      = 1'b0;
                        n_pos         = '0;
                        s_clear_lines = 1'b1;
                    end
                end else begin
                    s_data_byte         = 1'b1;
                    s_emit              = 1'b1;
                    s_result.pixel_byte = s_pixel;
                    n_pos               = s_pos_inc[POS_W-1:0];
                    if (s_pos_inc >= s_stride) begin
                        s_result.last_in_row = 1'b1;
                        n_expect             = 1'b1;
                        n_first_row          = 1'b0;
                        n_pos                = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_expect    <= 1'b1;
            r_filter    <= FILT_NONE;
            r_first_row <= 1'b1;
            r_halted    <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_expect    <= n_expect;
            r_filter    <= n_filter;
            r_first_row <= n_first_row;
            r_halted    <= n_halted;
        end
    end

    // Pixel delay lines: drop to zero at each valid filter byte, shift on each data byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || s_clear_lines) begin
            for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin
                r_left[i]  <= 8'd0;
                r_uleft[i] <= 8'd0;
            end
        end else if (s_data_byte) begin
            r_left[0]  <= s_pixel;
            r_uleft[0] <= s_up;
            for (int i = 1; i < MAX_BYTES_PER_PIXEL; i++) begin
                r_left[i]  <= r_left[i-1];
                r_uleft[i] <= r_uleft[i-1];
            end
        end
    end

    // Result register: hold while stalled, load on each emitted result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            r_out <= s_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for png_scanline_unfilter_unit: directed rows, then random images.
// Depends on src/pngunf_pkg.sv and src/png_scanline_unfilter_unit.sv.
`timescale 1ns / 1ps

module tb_top;
    import pngunf_pkg::*;

    localparam int STALL_LIMIT  = 2000;  // cycles without any handshake before giving up
    localparam int SETTLE_WAIT  = 4;     // input and result registers plus margin
    localparam int PHASE_ITEMS  = 125;
    localparam int NUM_PHASES   = 8;
    localparam int REPORT_LIMIT = 10;
    localparam int WIDE_BYTES   = 64;    // data bytes sent per row under the widest setting

    // Filter-type bytes outside the known set
    localparam logic [7:0] BAD_FILTER_LOW  = 8'(FILT_PAETH) + 8'd1;
    localparam logic [7:0] BAD_FILTER_HIGH = 8'hFF;

    // How each directed step is checked, or a register write
    typedef enum logic [1:0] {
        STEP_MODEL,  // expected pixel worked out by the predictor
        STEP_VALUE,  // expected result typed in the table
        STEP_NONE,   // request gives no result
        STEP_CFG     // register write while the block is idle
    } t_step_kind;

    typedef struct packed {
        t_step_kind            kind;
        t_in_item              req;
        t_out_item             want;
        t_cfg_index            sel;
        logic [CFG_DATA_W-1:0] val;
    } t_step;

    localparam int NUM_STEPS = 32;

    // Directed walk. Reset setting first (4 bytes per pixel, one pixel), then
    // three bytes per pixel with two pixels, narrowed to one pixel mid-row.
    localparam t_step DIRECTED_STEPS [NUM_STEPS] = '{
        // first row of an image, no filter: output equals input, extremes of the byte
        '{STEP_NONE,  '{8'(FILT_NONE), 1'b1}, '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_VALUE, '{8'h00, 1'b0},         '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_VALUE, '{8'hFF, 1'b0},         '{8'hFF, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_VALUE, '{8'h80, 1'b0},         '{8'h80, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_VALUE, '{8'h7F, 1'b0},         '{8'h7F, 1'b1, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        // unknown filter halts; a plain byte is dropped; a start marker while halted
        '{STEP_VALUE, '{BAD_FILTER_LOW, 1'b0},  '{8'h00, 1'b0, 1'b1}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_NONE,  '{8'hAA, 1'b0},           '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_VALUE, '{BAD_FILTER_HIGH, 1'b1}, '{8'h00, 1'b0, 1'b1}, CFG_BYTES_PER_PIXEL, '0},
        // RGB, two pixels per row
        '{STEP_CFG,   '{8'h00, 1'b0}, '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, 10'd3},
        '{STEP_CFG,   '{8'h00, 1'b0}, '{8'h00, 1'b0, 1'b0}, CFG_ROW_PIXELS,      10'd2},
        // up filter on the first row sees a zero row above
        '{STEP_NONE,  '{8'(FILT_UP), 1'b1},   '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_VALUE, '{8'h01, 1'b0},         '{8'h01, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_VALUE, '{8'hFE, 1'b0},         '{8'hFE, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_VALUE, '{8'h40, 1'b0},         '{8'h40, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_VALUE, '{8'h00, 1'b0},         '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_VALUE, '{8'hFF, 1'b0},         '{8'hFF, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_VALUE, '{8'h7E, 1'b0},         '{8'h7E, 1'b1, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        // sub filter: second pixel adds the first, first pixel sees zero on its left
        '{STEP_NONE,  '{8'(FILT_SUB), 1'b0},  '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_MODEL, '{8'h10, 1'b0},         '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_MODEL, '{8'h20, 1'b0},         '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_MODEL, '{8'h30, 1'b0},         '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_MODEL, '{8'hF0, 1'b0},         '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_MODEL, '{8'hE0, 1'b0},         '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_MODEL, '{8'hD0, 1'b0},         '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        // average filter, with the row narrowed to one pixel part way through
        '{STEP_NONE,  '{8'(FILT_AVERAGE), 1'b0}, '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_MODEL, '{8'h33, 1'b0},         '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_MODEL, '{8'hC4, 1'b0},         '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_CFG,   '{8'h00, 1'b0},         '{8'h00, 1'b0, 1'b0}, CFG_ROW_PIXELS,      10'd1},
        '{STEP_MODEL, '{8'h5A, 1'b0},         '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        // paeth row, abandoned by a start marker mid-row
        '{STEP_NONE,  '{8'(FILT_PAETH), 1'b0}, '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_MODEL, '{8'h9B, 1'b0},         '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0},
        '{STEP_NONE,  '{8'(FILT_NONE), 1'b1}, '{8'h00, 1'b0, 1'b0}, CFG_BYTES_PER_PIXEL, '0}
    };

    // Register settings of the random phases, field extremes among them
    localparam int PHASE_BPP [NUM_PHASES] = '{3, 0, 4, 7, 3, 1, 4, 2};
    localparam int PHASE_PIX [NUM_PHASES] = '{1, 0, 3, 2, 5, 9, 16, 6};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_index            i_cfg_index = CFG_BYTES_PER_PIXEL;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    png_scanline_unfilter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the block's registers and buffers
    // ------------------------------------------------------------------
    logic [BPP_W-1:0] cfg_bpp = BPP_W'(4);
    logic [PIX_W-1:0] cfg_pix = PIX_W'(1);
    logic [7:0]       prev_line [ROW_DEPTH];
    logic [7:0]       left_hist [MAX_BYTES_PER_PIXEL];
    logic [7:0]       uleft_hist [MAX_BYTES_PER_PIXEL];
    logic [POS_W-1:0] line_pos = '0;
    bit               want_filter = 1'b1;
    t_filter          cur_filter = FILT_NONE;
    bit               top_row = 1'b1;
    bit               halted = 1'b0;

    t_out_item pending_pixels [$];  // reconstructed bytes still owed by the block

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int burst_left     = 0;
    int stall_left     = 0;
    int stall_mode     = 0;
    int phase_sent;

    function automatic int pixel_bytes();
        if (cfg_bpp == 0)
            return 1;
        if (cfg_bpp > MAX_BYTES_PER_PIXEL)
            return MAX_BYTES_PER_PIXEL;
        return int'(cfg_bpp);
    endfunction

    function automatic int row_stride();
        int pix;
        pix = (cfg_pix == 0) ? 1 : int'(cfg_pix);
        if (pix > MAX_ROW_PIXELS)
            pix = MAX_ROW_PIXELS;
        return pix * pixel_bytes();
    endfunction

    function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        int p, pa, pb, pc;
        p  = int'(a) + int'(b) - int'(c);
        pa = (p >= int'(a)) ? p - int'(a) : int'(a) - p;
        pb = (p >= int'(b)) ? p - int'(b) : int'(b) - p;
        pc = (p >= int'(c)) ? p - int'(c) : int'(c) - p;
        if (pa <= pb && pa <= pc)
            return a;
        if (pb <= pc)
            return b;
        return c;
    endfunction

    // Advance the predictor by one accepted request; report the result it causes, if any
    task automatic unfilter_byte(input t_in_item req, output bit produced,
                                 output t_out_item res);
        int         lane;
        logic [7:0] up, left, uleft, pred, pix;
        logic [8:0] sum;
        produced = 1'b0;
        res = '0;
        if (req.first_of_image) begin
            halted = 1'b0;
            top_row = 1'b1;
            want_filter = 1'b1;
            line_pos = '0;
        end
        if (halted)
            return;
        if (want_filter) begin
            if (req.data_byte > 8'(FILT_PAETH)) begin
                halted = 1'b1;
                res.bad_filter = 1'b1;
                produced = 1'b1;
                return;
            end
            cur_filter = t_filter'(req.data_byte[2:0]);
            want_filter = 1'b0;
            line_pos = '0;
            for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin
                left_hist[i] = '0;
                uleft_hist[i] = '0;
            end
            return;
        end
        lane  = pixel_bytes() - 1;
        up    = top_row ? 8'h00 : prev_line[line_pos[POS_W-1:0]];
        left  = left_hist[lane];
        uleft = uleft_hist[lane];
        sum   = {1'b0, left} + {1'b0, up};
        case (cur_filter)
            FILT_SUB:     pred = left;
            FILT_UP:      pred = up;
            FILT_AVERAGE: pred = sum[8:1];
            FILT_PAETH:   pred = paeth_pick(left, up, uleft);
            default:      pred = 8'h00;
        endcase
        pix = req.data_byte + pred;
        prev_line[line_pos[POS_W-1:0]] = pix;
        for (int i = MAX_BYTES_PER_PIXEL - 1; i > 0; i--) begin
            left_hist[i] = left_hist[i-1];
            uleft_hist[i] = uleft_hist[i-1];
        end
        left_hist[0] = pix;
        uleft_hist[0] = up;
        // position counter is eleven bits wide, so the widest row wraps it to zero
        line_pos = line_pos + 1'b1;
        res.pixel_byte = pix;
        if (int'(line_pos) >= row_stride() || line_pos == 0) begin
            res.last_in_row = 1'b1;
            want_filter = 1'b1;
            top_row = 1'b0;
            line_pos = '0;
        end
        produced = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Request side: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    task automatic send_request(input t_in_item req, input t_step_kind kind,
                                input t_out_item want);
        bit        produced;
        t_out_item res;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 12)) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = req;
        // hold the request until the block takes it
        do @(posedge i_clk); while (o_in_stall);
        unfilter_byte(req, produced, res);
        if (kind == STEP_VALUE)
            pending_pixels.push_back(want);
        else if (kind == STEP_MODEL && produced)
            pending_pixels.push_back(res);
    endtask

    // Drop valid and wait for the pipeline to empty before touching the registers
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index sel, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = sel;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (sel == CFG_BYTES_PER_PIXEL)
            cfg_bpp = val[BPP_W-1:0];
        else
            cfg_pix = val[PIX_W-1:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_row(input t_filter filt, input bit first, input int count);
        send_request('{8'(filt), first}, STEP_MODEL, '0);
        repeat (count)
            send_request('{8'($urandom_range(0, 255)), 1'b0}, STEP_MODEL, '0);
    endtask

    // One random image: mostly whole rows with random filters and content; now and
    // then an unknown filter followed by noise, or a row cut short by the next image
    task automatic send_image();
        int         rows, count;
        logic [7:0] code;
        rows = $urandom_range(1, 5);
        for (int r = 0; r < rows; r++) begin
            if ($urandom_range(0, 99) < 5)
                code = 8'($urandom_range(int'(BAD_FILTER_LOW), 255));
            else
                code = 8'($urandom_range(int'(FILT_NONE), int'(FILT_PAETH)));
            send_request('{code, r == 0}, STEP_MODEL, '0);
            phase_sent++;
            if (code > 8'(FILT_PAETH)) begin
                // halted: these bytes are dropped and not counted
                repeat ($urandom_range(0, 3))
                    send_request('{8'($urandom_range(0, 255)), 1'b0}, STEP_MODEL, '0);
                return;
            end
            count = row_stride();
            if ($urandom_range(0, 99) < 4)
                count = $urandom_range(0, count - 1);
            repeat (count)
                send_request('{8'($urandom_range(0, 255)), 1'b0}, STEP_MODEL, '0);
            phase_sent += count;
            if (count < row_stride())
                return;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern of its own
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(1, 30);
        end
        stall_left--;
        case (stall_mode)
            0:       i_out_stall = 1'b0;
            1:       i_out_stall = 1'b1;
            default: i_out_stall = 1'($urandom_range(0, 1));
        endcase
    end

    task automatic note_failure(input string what, input t_out_item want,
                                input t_out_item got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t %s: expected pixel=%02h last=%0b bad=%0b, got pixel=%02h last=%0b bad=%0b",
                     $realtime, what, want.pixel_byte, want.last_in_row, want.bad_filter,
                     got.pixel_byte, got.last_in_row, got.bad_filter);
    endtask

    t_out_item oldest_pixel;

    // Compare every accepted result with the oldest outstanding expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                note_failure("result with no request waiting", '0, o_out_data);
            end else begin
                oldest_pixel = pending_pixels.pop_front();
                if (o_out_data.pixel_byte !== oldest_pixel.pixel_byte ||
                    o_out_data.last_in_row !== oldest_pixel.last_in_row ||
                    o_out_data.bad_filter !== oldest_pixel.bad_filter)
                    note_failure("result mismatch", oldest_pixel, o_out_data);
            end
        end
    end

    // Give up when no channel has moved for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < ROW_DEPTH; i++)
            prev_line[i] = '0;
        for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin
            left_hist[i] = '0;
            uleft_hist[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed walk: register writes wait for an idle block
        for (int s = 0; s < NUM_STEPS; s++) begin
            if (DIRECTED_STEPS[s].kind == STEP_CFG) begin
                drain_results();
                write_register(DIRECTED_STEPS[s].sel, DIRECTED_STEPS[s].val);
            end else begin
                send_request(DIRECTED_STEPS[s].req, DIRECTED_STEPS[s].kind,
                             DIRECTED_STEPS[s].want);
            end
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            write_register(CFG_BYTES_PER_PIXEL, CFG_DATA_W'(PHASE_BPP[ph]));
            write_register(CFG_ROW_PIXELS, CFG_DATA_W'(PHASE_PIX[ph]));
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS) begin
                // hold off now and then until every result is back
                if ($urandom_range(0, 29) == 0)
                    drain_results();
                send_image();
            end
        end

        // Widest setting: field maxima clamp to four bytes and the longest row;
        // send the head of a row, then abandon it with a new image
        drain_results();
        write_register(CFG_BYTES_PER_PIXEL, CFG_DATA_W'(2**BPP_W - 1));
        write_register(CFG_ROW_PIXELS, CFG_DATA_W'(2**PIX_W - 1));
        send_row(FILT_PAETH, 1'b1, WIDE_BYTES);
        send_row(FILT_AVERAGE, 1'b1, WIDE_BYTES);

        drain_results();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
